[hw/rtl/grmas_pkg.sv]
// ----------------------------------------------------------------------------
// grmas_pkg
// shared types and constants of the gated running median / average smoother
// ----------------------------------------------------------------------------
package grmas_pkg;

  localparam int MEDIAN_DEPTH_DEF  = 2048;
  localparam int AVERAGE_DEPTH_DEF = 256;
  localparam int SAMPLE_WIDTH_DEF  = 32;

  localparam int LIMIT_W   = 31;
  localparam int MED_LEN_W = 12;
  localparam int AVG_LEN_W = 9;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_REAL = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_IMAG = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_REAL   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_IMAG   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FILL_MEDIAN  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FLAG_MODE    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MEDIAN_LEN   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_AVERAGE_LEN  = 3'd7;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_STEP,
    ST_AVG_WR,
    ST_SUM,
    ST_SUM_END,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  // per-cycle strobes from the sequencer to both lanes
  typedef struct packed {
    logic clear_med;
    logic clear_avg;
    logic load;
    logic scan_rd;
    logic step;
    logic avg_wr;
    logic sum_clr;
    logic sum_rd;
    logic div_go;
  } lane_ctrl_t;

  typedef struct packed {
    logic div_done;
  } lane_sts_t;

endpackage

[hw/rtl/grmas_ram.sv]
// ----------------------------------------------------------------------------
// grmas_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module grmas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/grmas_div.sv]
// ----------------------------------------------------------------------------
// grmas_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module grmas_div #(
  parameter int NW = 41,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   sh;
  logic [DW:0]   diff;
  logic          ge;

  assign sh   = {rem, quotient[NW-1]};
  assign diff = sh - {1'b0, divisor};
  assign ge   = (sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[DW-1:0] : sh[DW-1:0];
      quotient <= {quotient[NW-2:0], ge};
    end
  end

endmodule

[hw/rtl/grmas_lane.sv]
// ----------------------------------------------------------------------------
// grmas_lane
// one smoothing lane: gate, median window scan, median step, average
// ----------------------------------------------------------------------------
module grmas_lane #(
  parameter int SW = 32,
  parameter int MD = 2048,
  parameter int AD = 256,
  parameter logic [SW-1:0] RST_VAL = '0,
  localparam int NW   = $clog2(MD + 1),
  localparam int ALW  = $clog2(AD + 1),
  localparam int MAW  = (MD > 1) ? $clog2(MD) : 1,
  localparam int AAW  = (AD > 1) ? $clog2(AD) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  grmas_pkg::lane_ctrl_t       ctrl,
  input  logic signed [SW-1:0]        sample,
  input  logic                        is_gap,
  input  logic signed [SW-1:0]        dflt,
  input  logic [grmas_pkg::LIMIT_W-1:0] limit,
  input  logic                        fill_med,
  input  logic                        flag_mode,
  input  logic [NW-1:0]               n,
  input  logic [ALW-1:0]              an,
  input  logic [MAW-1:0]              med_wr_addr,
  input  logic [MAW-1:0]              med_rd_addr,
  input  logic [AAW-1:0]              avg_wr_addr,
  input  logic [AAW-1:0]              avg_rd_addr,
  output grmas_pkg::lane_sts_t        sts,
  output logic signed [SW-1:0]        res
);
  import grmas_pkg::*;

  localparam int CW   = ((SW > LIMIT_W) ? SW : LIMIT_W) + 2;
  localparam int SUMW = SW + AAW + 1;
  localparam logic [SW-1:0] QONE = {3'b000, 1'b1, {(SW-4){1'b0}}};

  function automatic logic signed [SW-1:0] half_sum(input logic signed [SW-1:0] a,
                                                    input logic signed [SW-1:0] b);
    logic signed [SW:0] s;
    s = (SW+1)'(a) + (SW+1)'(b);
    s = s + {{SW{1'b0}}, s[SW]};
    return s[SW:1];
  endfunction

  logic signed [SW-1:0] cur;
  logic signed [CW-1:0] xw, lo, hi, limw;
  logic                 reject;
  logic signed [SW-1:0] v;

  // gate: gap and zero check, wide compare against default +/- limit
  always_comb begin
    xw     = CW'(sample);
    limw   = CW'({1'b0, limit});
    hi     = CW'(dflt) + limw;
    lo     = CW'(dflt) - limw;
    reject = is_gap || (sample == '0) || (xw > hi) || (xw < lo);
    v      = reject ? (fill_med ? cur : dflt) : sample;
  end

  logic [SW-1:0] mdata, adata;

  grmas_ram #(.WIDTH(SW), .DEPTH(MD)) u_med_ram (
    .clk     (clk),
    .wr_en   (ctrl.clear_med | ctrl.load),
    .wr_addr (med_wr_addr),
    .wr_data (ctrl.clear_med ? RST_VAL : v),
    .rd_en   (ctrl.scan_rd),
    .rd_addr (med_rd_addr),
    .rd_data (mdata)
  );

  grmas_ram #(.WIDTH(SW), .DEPTH(AD)) u_avg_ram (
    .clk     (clk),
    .wr_en   (ctrl.clear_avg | ctrl.avg_wr),
    .wr_addr (avg_wr_addr),
    .wr_data (ctrl.clear_avg ? RST_VAL : cur),
    .rd_en   (ctrl.sum_rd),
    .rd_addr (avg_rd_addr),
    .rd_data (adata)
  );

  // window scan: counts and nearest neighbours around the tracked median
  logic                 scan_vld, sum_vld;
  logic signed [SW-1:0] w;
  logic [NW-1:0]        nl, ng;
  logic signed [SW-1:0] l1, l2, g1, g2;

  assign w = mdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_vld <= 1'b0;
      sum_vld  <= 1'b0;
    end else begin
      scan_vld <= ctrl.scan_rd;
      sum_vld  <= ctrl.sum_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      nl <= '0;
      ng <= '0;
    end else if (scan_vld) begin
      if (w < cur) begin
        if (nl == '0) begin
          l1 <= w;
        end else if (w > l1) begin
          l2 <= l1;
          l1 <= w;
        end else if (nl == NW'(1) || w > l2) begin
          l2 <= w;
        end
        nl <= nl + 1'b1;
      end else if (w > cur) begin
        if (ng == '0) begin
          g1 <= w;
        end else if (w < g1) begin
          g2 <= g1;
          g1 <= w;
        end else if (ng == NW'(1) || w < g2) begin
          g2 <= w;
        end
        ng <= ng + 1'b1;
      end
    end
  end

  // one step of the tracked median toward the window median
  logic [NW-1:0]        h;
  logic signed [SW-1:0] step_val;

  always_comb begin
    h        = n >> 1;
    step_val = cur;
    if (!n[0]) begin
      if (nl == h && ng == h) begin
        step_val = half_sum(g1, l1);
      end else if (ng > h) begin
        step_val = half_sum(g1, g2);
      end else if (nl > h) begin
        step_val = half_sum(l1, l2);
      end else if (ng == h && nl < h) begin
        step_val = half_sum(cur, g1);
      end else if (nl == h && ng < h) begin
        step_val = half_sum(cur, l1);
      end
    end else begin
      if (ng > h) begin
        step_val = g1;
      end else if (nl > h) begin
        step_val = l1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= RST_VAL;
    end else if (ctrl.step) begin
      cur <= step_val;
    end
  end

  // average window sum and division
  logic signed [SUMW-1:0] sum;
  logic [SUMW-1:0]        mag, quo;
  logic signed [SW-1:0]   avg;

  always_ff @(posedge clk) begin
    if (ctrl.sum_clr) begin
      sum <= '0;
    end else if (sum_vld) begin
      sum <= sum + SUMW'($signed(adata));
    end
  end

  assign mag = sum[SUMW-1] ? -sum : sum;

  grmas_div #(.NW(SUMW), .DW(ALW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (ctrl.div_go),
    .dividend (mag),
    .divisor  (an),
    .quotient (quo),
    .done     (sts.div_done)
  );

  always_comb begin
    avg = sum[SUMW-1] ? -quo[SW-1:0] : quo[SW-1:0];
    if (flag_mode) begin
      res = (avg != dflt) ? QONE : '0;
    end else begin
      res = avg;
    end
  end

endmodule

[hw/rtl/gated_running_median_average_smoother.sv]
// ----------------------------------------------------------------------------
// gated_running_median_average_smoother
// two-lane gated running median and moving average smoother, apb configured
// ----------------------------------------------------------------------------
// sequence: one median window entry is read per cycle, then one average window
//   entry per cycle, then one quotient bit per cycle
// throughput: one item at a time; the next transfer is taken once the result
//   sits in the output register
// reset: synchronous; a clearing pass over max(MEDIAN_DEPTH, AVERAGE_DEPTH) entries
//   fills all windows with the reset defaults, no input meanwhile
module gated_running_median_average_smoother
  import grmas_pkg::*;
#(
  parameter int MEDIAN_DEPTH  = grmas_pkg::MEDIAN_DEPTH_DEF,
  parameter int AVERAGE_DEPTH = grmas_pkg::AVERAGE_DEPTH_DEF,
  parameter int SAMPLE_WIDTH  = grmas_pkg::SAMPLE_WIDTH_DEF,
  localparam int PDW = (SAMPLE_WIDTH > 32) ? 64 : 32,
  localparam int ALSB = (SAMPLE_WIDTH > 32) ? 3 : 2,
  localparam int PAW = ALSB + grmas_pkg::REG_IDX_W
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [PAW-1:0]                 paddr,
  input  logic [PDW-1:0]                 pwdata,
  output logic [PDW-1:0]                 prdata,
  output logic                           pready,
  // input channel
  input  logic signed [SAMPLE_WIDTH-1:0] sample_real,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_imag,
  input  logic                           is_gap,
  input  logic                           in_valid,
  output logic                           in_stall,
  // output channel
  output logic signed [SAMPLE_WIDTH-1:0] smoothed_real,
  output logic signed [SAMPLE_WIDTH-1:0] smoothed_imag,
  output logic                           out_valid,
  input  logic                           out_stall
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int NW   = $clog2(MEDIAN_DEPTH + 1);
  localparam int ALW  = $clog2(AVERAGE_DEPTH + 1);
  localparam int MAW  = (MEDIAN_DEPTH > 1) ? $clog2(MEDIAN_DEPTH) : 1;
  localparam int AAW  = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int CLR_N = (MEDIAN_DEPTH > AVERAGE_DEPTH) ? MEDIAN_DEPTH : AVERAGE_DEPTH;
  localparam int CNTW = $clog2(CLR_N + 1);
  localparam logic [SW-1:0] QONE = {3'b000, 1'b1, {(SW-4){1'b0}}};

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [SW-1:0]  default_real, default_imag;
  logic [LIMIT_W-1:0]    offset_limit_real, offset_limit_imag;
  logic                  fill_with_median, flag_output_mode;
  logic [MED_LEN_W-1:0]  median_length;
  logic [AVG_LEN_W-1:0]  average_length;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ALSB +: REG_IDX_W];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_real      <= QONE;
      default_imag      <= '0;
      offset_limit_real <= '1;
      offset_limit_imag <= '1;
      fill_with_median  <= 1'b0;
      flag_output_mode  <= 1'b0;
      median_length     <= MED_LEN_W'(2048);
      average_length    <= AVG_LEN_W'(1);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEFAULT_REAL: default_real      <= pwdata[SW-1:0];
        REG_DEFAULT_IMAG: default_imag      <= pwdata[SW-1:0];
        REG_LIMIT_REAL:   offset_limit_real <= pwdata[LIMIT_W-1:0];
        REG_LIMIT_IMAG:   offset_limit_imag <= pwdata[LIMIT_W-1:0];
        REG_FILL_MEDIAN:  fill_with_median  <= pwdata[0];
        REG_FLAG_MODE:    flag_output_mode  <= pwdata[0];
        REG_MEDIAN_LEN:   median_length     <= pwdata[MED_LEN_W-1:0];
        REG_AVERAGE_LEN:  average_length    <= pwdata[AVG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEFAULT_REAL: prdata = PDW'($unsigned(default_real));
      REG_DEFAULT_IMAG: prdata = PDW'($unsigned(default_imag));
      REG_LIMIT_REAL:   prdata = PDW'(offset_limit_real);
      REG_LIMIT_IMAG:   prdata = PDW'(offset_limit_imag);
      REG_FILL_MEDIAN:  prdata = PDW'(fill_with_median);
      REG_FLAG_MODE:    prdata = PDW'(flag_output_mode);
      REG_MEDIAN_LEN:   prdata = PDW'(median_length);
      REG_AVERAGE_LEN:  prdata = PDW'(average_length);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // effective lengths and window positions
  // --------------------------------------------------------------------------
  logic [NW-1:0]  n;
  logic [ALW-1:0] an;
  logic [MAW-1:0] median_write_pos, mp;
  logic [AAW-1:0] average_write_pos, ap;

  // zero acts as one, anything above the depth as the depth
  always_comb begin
    if (median_length == '0) begin
      n = NW'(1);
    end else if (32'(median_length) > 32'(MEDIAN_DEPTH)) begin
      n = NW'(MEDIAN_DEPTH);
    end else begin
      n = NW'(median_length);
    end
    if (average_length == '0) begin
      an = ALW'(1);
    end else if (32'(average_length) > 32'(AVERAGE_DEPTH)) begin
      an = ALW'(AVERAGE_DEPTH);
    end else begin
      an = ALW'(average_length);
    end
    // a position left beyond a shortened window restarts at entry 0
    mp = (32'(median_write_pos) < 32'(n)) ? median_write_pos : '0;
    ap = (32'(average_write_pos) < 32'(an)) ? average_write_pos : '0;
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  state_t        state, state_next;
  logic [CNTW-1:0] cnt, cnt_next;
  lane_ctrl_t    ctrl;
  lane_sts_t     sts_real, sts_imag;
  logic          out_load;
  logic [MAW-1:0] med_wr_addr;
  logic [AAW-1:0] avg_wr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctrl       = '0;
    out_load   = 1'b0;
    case (state)
      ST_CLEAR: begin
        // sweep all window entries with the reset defaults
        ctrl.clear_med = (32'(cnt) < 32'(MEDIAN_DEPTH));
        ctrl.clear_avg = (32'(cnt) < 32'(AVERAGE_DEPTH));
        if (32'(cnt) == 32'(CLR_N - 1)) begin
          state_next = ST_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_IDLE: begin
        // transfer accepted: new value goes into the median window now
        if (in_valid) begin
          ctrl.load  = 1'b1;
          cnt_next   = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctrl.scan_rd = 1'b1;
        if (32'(cnt) == 32'(n) - 32'd1) begin
          cnt_next   = '0;
          state_next = ST_SCAN_END;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SCAN_END: begin
        // last read word is folded in this cycle
        state_next = ST_STEP;
      end
      ST_STEP: begin
        ctrl.step  = 1'b1;
        state_next = ST_AVG_WR;
      end
      ST_AVG_WR: begin
        ctrl.avg_wr  = 1'b1;
        ctrl.sum_clr = 1'b1;
        cnt_next     = '0;
        state_next   = ST_SUM;
      end
      ST_SUM: begin
        ctrl.sum_rd = 1'b1;
        if (32'(cnt) == 32'(an) - 32'd1) begin
          cnt_next   = '0;
          state_next = ST_SUM_END;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SUM_END: begin
        state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        ctrl.div_go = 1'b1;
        state_next  = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts_real.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // hand over once the output register is free
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall    = (state != ST_IDLE);
  assign med_wr_addr = (state == ST_CLEAR) ? cnt[MAW-1:0] : mp;
  assign avg_wr_addr = (state == ST_CLEAR) ? cnt[AAW-1:0] : ap;

  // write positions advance once per item, shared by both lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      median_write_pos  <= '0;
      average_write_pos <= '0;
    end else if (out_load) begin
      median_write_pos  <= (32'(mp) + 32'd1 < 32'(n)) ? mp + 1'b1 : '0;
      average_write_pos <= (32'(ap) + 32'd1 < 32'(an)) ? ap + 1'b1 : '0;
    end
  end

  // --------------------------------------------------------------------------
  // lanes
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] res_real, res_imag;

  grmas_lane #(
    .SW(SW), .MD(MEDIAN_DEPTH), .AD(AVERAGE_DEPTH), .RST_VAL(QONE)
  ) u_lane_real (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .sample      (sample_real),
    .is_gap      (is_gap),
    .dflt        (default_real),
    .limit       (offset_limit_real),
    .fill_med    (fill_with_median),
    .flag_mode   (flag_output_mode),
    .n           (n),
    .an          (an),
    .med_wr_addr (med_wr_addr),
    .med_rd_addr (cnt[MAW-1:0]),
    .avg_wr_addr (avg_wr_addr),
    .avg_rd_addr (cnt[AAW-1:0]),
    .sts         (sts_real),
    .res         (res_real)
  );

  grmas_lane #(
    .SW(SW), .MD(MEDIAN_DEPTH), .AD(AVERAGE_DEPTH), .RST_VAL('0)
  ) u_lane_imag (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .sample      (sample_imag),
    .is_gap      (is_gap),
    .dflt        (default_imag),
    .limit       (offset_limit_imag),
    .fill_med    (fill_with_median),
    .flag_mode   (flag_output_mode),
    .n           (n),
    .an          (an),
    .med_wr_addr (med_wr_addr),
    .med_rd_addr (cnt[MAW-1:0]),
    .avg_wr_addr (avg_wr_addr),
    .avg_rd_addr (cnt[AAW-1:0]),
    .sts         (sts_imag),
    .res         (res_imag)
  );

  // --------------------------------------------------------------------------
  // output register, merges both lane results into one transfer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      smoothed_real <= res_real;
      smoothed_imag <= res_imag;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result appeared without a finished item");

  a_no_out_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !out_valid)
    else $error("result during clearing pass");

  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> sts_real.div_done && sts_imag.div_done)
    else $error("lane dividers out of step");

endmodule
